### design/flna_pkg.sv
// ----------------------------------------------------------------------------
// flna_pkg
// Shared constants, format codes and control structs of the number to ASCII
// digit formatter.
// ----------------------------------------------------------------------------
package flna_pkg;

    // Significant bits of the incoming number (8..32)
    localparam int NUMBER_WIDTH = 32;
    localparam logic [31:0] NUM_MASK = 32'((64'd1 << NUMBER_WIDTH) - 64'd1);

    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int SR_W       = 40;
    localparam int CNT_W      = $clog2(NUMBER_WIDTH + 1);

    // Formats
    localparam logic [1:0] FMT_UDEC = 2'd0;
    localparam logic [1:0] FMT_SDEC = 2'd1;
    localparam logic [1:0] FMT_HEX  = 2'd2;
    localparam logic [1:0] FMT_BIN  = 2'd3;

    // Digit count limits
    localparam logic [4:0] MAX_DEC = 5'd10;
    localparam logic [4:0] MAX_HEX = 5'd8;
    localparam logic [4:0] MAX_BIN = 5'd16;

    // Character codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bcd_stat;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic [1:0] fmt;
    } t_sr_ctrl;

endpackage

### design/fixed_length_number_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// fixed_length_number_to_ascii_digits
// Formats a number as a run of ASCII digits tagged with line and column.
// ----------------------------------------------------------------------------
// One request at a time. A decimal request runs through the bit-serial BCD
// converter and waits to see it finish, then a load step, then an alignment
// step that discards unwanted high digits, then one character per cycle while
// the output is not stalled (the sign first for signed decimal), then a return
// to idle before the next request is taken. Hex and binary skip the converter.
// Characters leave through an output register, so a stalled output only holds
// the character stream and adds the stall length. The next request is taken
// once the last character of the current run has been written to the output
// register.
module fixed_length_number_to_ascii_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_number,
    input  logic [4:0]  i_digit_count,
    input  logic [2:0]  i_line,
    input  logic [4:0]  i_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_out_line,
    output logic [4:0]  o_out_column,
    output logic [6:0]  o_char_code,
    output logic        o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_SIGN  = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_fmt, n_fmt;
    logic [31:0] r_value, n_value;
    logic        r_neg, n_neg;
    logic [4:0]  r_len, n_len;
    logic [3:0]  r_skip, n_skip;
    logic [2:0]  r_line, n_line;
    logic [4:0]  r_col, n_col;

    logic        r_o_valid, n_o_valid;
    logic [2:0]  r_o_line, n_o_line;
    logic [4:0]  r_o_col, n_o_col;
    logic [6:0]  r_o_char, n_o_char;
    logic        r_o_last, n_o_last;

    logic        w_accept;
    logic        w_adv;
    logic        w_dec;
    logic [31:0] w_num;
    logic [31:0] w_mag;
    logic        w_sign;
    logic [4:0]  w_max;
    logic [4:0]  w_len;
    logic [6:0]  w_char;

    flna_pkg::t_bcd_stat           s_bcd;
    flna_pkg::t_sr_ctrl            s_sr;
    logic [flna_pkg::BCD_W-1:0]    w_bcd;

    assign w_accept = i_valid && !o_stall;
    assign w_adv    = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // Request decode
    assign w_num  = i_number & flna_pkg::NUM_MASK;
    assign w_sign = w_num[flna_pkg::NUMBER_WIDTH-1];
    assign w_mag  = (~w_num + 32'd1) & flna_pkg::NUM_MASK;
    assign w_dec  = (i_action == flna_pkg::FMT_UDEC) || (i_action == flna_pkg::FMT_SDEC);

    always_comb begin
        case (i_action)
            flna_pkg::FMT_HEX: w_max = flna_pkg::MAX_HEX;
            flna_pkg::FMT_BIN: w_max = flna_pkg::MAX_BIN;
            default:           w_max = flna_pkg::MAX_DEC;
        endcase
        if (i_digit_count == 5'd0) begin
            w_len = 5'd1;
        end else if (i_digit_count > w_max) begin
            w_len = w_max;
        end else begin
            w_len = i_digit_count;
        end
    end

    flna_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_dec),
        .i_value (n_value[flna_pkg::NUMBER_WIDTH-1:0]),
        .o_stat  (s_bcd),
        .o_bcd   (w_bcd)
    );

    assign s_sr.load  = (r_state == ST_LOAD);
    assign s_sr.shift = ((r_state == ST_ALIGN) && (r_skip != 4'd0))
                     || ((r_state == ST_DIGIT) && w_adv);
    assign s_sr.fmt   = r_fmt;

    flna_digit_sr u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (s_sr),
        .i_value (r_value),
        .i_bcd   (w_bcd),
        .o_char  (w_char)
    );

    always_comb begin
        n_state   = r_state;
        n_fmt     = r_fmt;
        n_value   = r_value;
        n_neg     = r_neg;
        n_len     = r_len;
        n_skip    = r_skip;
        n_line    = r_line;
        n_col     = r_col;
        n_o_valid = r_o_valid && i_stall;
        n_o_line  = r_o_line;
        n_o_col   = r_o_col;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_fmt   = i_action;
                    n_neg   = (i_action == flna_pkg::FMT_SDEC) && w_sign;
                    n_value = ((i_action == flna_pkg::FMT_SDEC) && w_sign) ? w_mag : w_num;
                    n_len   = w_len;
                    n_skip  = 4'(w_max - w_len);
                    n_line  = i_line;
                    n_col   = i_column;
                    n_state = w_dec ? ST_CONV : ST_LOAD;
                end
            end
            ST_CONV: begin
                if (s_bcd.done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_ALIGN;
            end
            ST_ALIGN: begin
                // Drop the unwanted high digits
                if (r_skip != 4'd0) begin
                    n_skip = r_skip - 4'd1;
                end else if (r_fmt == flna_pkg::FMT_SDEC) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (w_adv) begin
                    n_o_valid = 1'b1;
                    n_o_line  = r_line;
                    n_o_col   = r_col;
                    n_o_char  = r_neg ? flna_pkg::CH_MINUS : flna_pkg::CH_PLUS;
                    n_o_last  = 1'b0;
                    n_col     = r_col + 5'd1;
                    n_state   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_adv) begin
                    n_o_valid = 1'b1;
                    n_o_line  = r_line;
                    n_o_col   = r_col;
                    n_o_char  = w_char;
                    n_o_last  = (r_len == 5'd1);
                    n_col     = r_col + 5'd1;
                    n_len     = r_len - 5'd1;
                    if (r_len == 5'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_fmt     <= flna_pkg::FMT_UDEC;
            r_len     <= '0;
            r_skip    <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_fmt     <= n_fmt;
            r_len     <= n_len;
            r_skip    <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_neg    <= n_neg;
        r_line   <= n_line;
        r_col    <= n_col;
        r_o_line <= n_o_line;
        r_o_col  <= n_o_col;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_valid      = r_o_valid;
    assign o_out_line   = r_o_line;
    assign o_out_column = r_o_col;
    assign o_char_code  = r_o_char;
    assign o_last       = r_o_last;

    a_digit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT) |-> (r_len != 5'd0))
        else $error("digit phase entered with no digits left");

    a_conv_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_bcd.busy |-> (r_state == ST_CONV))
        else $error("BCD converter running outside conversion phase");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIGIT) && w_adv && (r_len == 5'd1)) |=>
        ((r_state == ST_IDLE) && o_valid && o_last))
        else $error("final character did not close the run");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == ST_CONV) || (r_state == ST_LOAD)))
        else $error("accepted request did not start");

endmodule

### design/flna_bcd.sv
// ----------------------------------------------------------------------------
// flna_bcd
// Bit-serial binary to BCD converter (shift and add 3), one input bit per
// cycle, shifting in all NUMBER_WIDTH input bits per conversion.
// ----------------------------------------------------------------------------
module flna_bcd (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [flna_pkg::NUMBER_WIDTH-1:0]    i_value,
    output flna_pkg::t_bcd_stat                  o_stat,
    output logic [flna_pkg::BCD_W-1:0]           o_bcd
);

    logic [flna_pkg::NUMBER_WIDTH-1:0] r_bin, n_bin;
    logic [flna_pkg::BCD_W-1:0]        r_bcd, n_bcd;
    logic [flna_pkg::BCD_W-1:0]        w_adj;
    logic [flna_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic                              r_busy, n_busy;
    logic                              r_done, n_done;

    // Correct every digit that would overflow past 9 when doubled
    always_comb begin
        for (int d = 0; d < flna_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[flna_pkg::BCD_W-2:0], r_bin[flna_pkg::NUMBER_WIDTH-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == flna_pkg::CNT_W'(flna_pkg::NUMBER_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_bcd  <= '0;
            r_bin  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_bcd  <= n_bcd;
            r_bin  <= n_bin;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

endmodule

### design/flna_digit_sr.sv
// ----------------------------------------------------------------------------
// flna_digit_sr
// Digit shift register: holds the digits left-aligned and presents the top
// digit as an ASCII character, one binary bit or one nibble per shift.
// ----------------------------------------------------------------------------
module flna_digit_sr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  flna_pkg::t_sr_ctrl            i_ctrl,
    input  logic [31:0]                   i_value,
    input  logic [flna_pkg::BCD_W-1:0]    i_bcd,
    output logic [6:0]                    o_char
);

    logic [flna_pkg::SR_W-1:0] r_sr, n_sr;
    logic [1:0]                r_fmt, n_fmt;
    logic [3:0]                w_nib;

    always_comb begin
        n_sr  = r_sr;
        n_fmt = r_fmt;
        if (i_ctrl.load) begin
            n_fmt = i_ctrl.fmt;
            case (i_ctrl.fmt)
                flna_pkg::FMT_HEX: n_sr = {i_value, 8'h00};
                flna_pkg::FMT_BIN: n_sr = {i_value[15:0], 24'h000000};
                default:           n_sr = i_bcd;
            endcase
        end else if (i_ctrl.shift) begin
            if (r_fmt == flna_pkg::FMT_BIN) begin
                n_sr = r_sr << 1;
            end else begin
                n_sr = r_sr << 4;
            end
        end
    end

    assign w_nib = r_sr[flna_pkg::SR_W-1 -: 4];

    always_comb begin
        if (r_fmt == flna_pkg::FMT_BIN) begin
            o_char = flna_pkg::CH_ZERO + 7'(r_sr[flna_pkg::SR_W-1]);
        end else if (w_nib < 4'd10) begin
            o_char = flna_pkg::CH_ZERO + 7'(w_nib);
        end else begin
            o_char = flna_pkg::CH_UPPER + 7'(w_nib - 4'd10);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr  <= '0;
            r_fmt <= flna_pkg::FMT_UDEC;
        end else begin
            r_sr  <= n_sr;
            r_fmt <= n_fmt;
        end
    end

endmodule
